[rtl/wor_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wor_pkg;

    // default geometry of the string store
    localparam int BYTE_DEPTH = 32;
    localparam int MAX_WORDS  = 16;

    // depth of the command queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 4;

    // register and byte codes
    localparam logic [7:0] SEPARATOR_RESET = 8'd32;
    localparam logic [7:0] SPACE_BYTE      = 8'd32;
    localparam logic [7:0] NEWLINE_BYTE    = 8'd10;

    // queue status seen by the back and by the top-level busy logic
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

[rtl/wor_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module wor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_we,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                       i_wdata,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/wor_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module wor_queue #(
    parameter int WIDTH = 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire [WIDTH-1:0]        i_data,
    input  wire                    i_pop,
    output logic [WIDTH-1:0]       o_data,
    output wor_pkg::t_q_status     o_status
);

    localparam int QD  = wor_pkg::QUEUE_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    logic [WIDTH-1:0] r_mem [QD];
    logic [QAW-1:0]   r_wptr;
    logic [QAW-1:0]   r_rptr;
    logic [QCW-1:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == QCW'(QD));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_data  = r_mem[r_rptr];

    // item storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QAW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QAW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/wor_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module wor_front #(
    parameter int BYTE_DEPTH = wor_pkg::BYTE_DEPTH,
    parameter int MAX_WORDS  = wor_pkg::MAX_WORDS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_valid,
    input  wire [7:0]  i_cfg_data,
    input  wire        i_accept,
    input  wire [7:0]  i_ch,
    input  wire        i_is_end,
    output logic       o_push,
    output logic [2 + $clog2(MAX_WORDS + 1) + 8 + 2 * $clog2(BYTE_DEPTH)
                  + (MAX_WORDS > 1 ? $clog2(MAX_WORDS) : 1)
                  + $clog2(BYTE_DEPTH + 1) - 1:0] o_cmd
);

    localparam int AW  = $clog2(BYTE_DEPTH);
    localparam int CW  = $clog2(BYTE_DEPTH + 1);
    localparam int WIW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int WCW = $clog2(MAX_WORDS + 1);

    typedef struct packed {
        logic           is_end;
        logic           dropped;
        logic [WCW-1:0] wcount;
        logic [7:0]     data;
        logic [AW-1:0]  addr;
        logic [WIW-1:0] widx;
        logic [AW-1:0]  wstart;
        logic [CW-1:0]  wlen;
    } t_cmd;

    logic [7:0]     r_sep;
    logic [CW-1:0]  r_bcount;
    logic [WCW-1:0] r_wcount;
    logic           r_inside;
    logic           r_live;
    logic           r_dropped;
    logic [AW-1:0]  r_cur_start;
    logic [CW-1:0]  r_cur_len;

    logic [CW-1:0]  n_bcount;
    logic [WCW-1:0] n_wcount;
    logic           n_inside;
    logic           n_live;
    logic           n_dropped;
    logic [AW-1:0]  n_cur_start;
    logic [CW-1:0]  n_cur_len;

    t_cmd           cmd;
    logic           push;
    logic           room_bytes;
    logic           room_words;
    logic [WCW-1:0] wcount_m1;

    assign room_bytes = (r_bcount < CW'(BYTE_DEPTH));
    assign room_words = (r_wcount < WCW'(MAX_WORDS));
    assign wcount_m1  = r_wcount - WCW'(1);

    // separator register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= wor_pkg::SEPARATOR_RESET;
        end else if (i_cfg_valid) begin
            r_sep <= i_cfg_data;
        end
    end

    // classify the item and build the store or end command
    always_comb begin
        n_bcount    = r_bcount;
        n_wcount    = r_wcount;
        n_inside    = r_inside;
        n_live      = r_live;
        n_dropped   = r_dropped;
        n_cur_start = r_cur_start;
        n_cur_len   = r_cur_len;
        push        = 1'b0;
        cmd         = '0;
        cmd.data    = i_ch;
        cmd.addr    = r_bcount[AW-1:0];
        if (i_accept) begin
            if (i_is_end) begin
                push        = 1'b1;
                cmd.is_end  = 1'b1;
                cmd.dropped = r_dropped;
                cmd.wcount  = r_wcount;
                n_bcount    = '0;
                n_wcount    = '0;
                n_inside    = 1'b0;
                n_live      = 1'b0;
                n_dropped   = 1'b0;
            end else if (i_ch == r_sep) begin
                n_inside = 1'b0;
                n_live   = 1'b0;
            end else if (!r_inside) begin
                // first byte of a new word
                n_inside = 1'b1;
                if (room_words && room_bytes) begin
                    push        = 1'b1;
                    cmd.widx    = r_wcount[WIW-1:0];
                    cmd.wstart  = r_bcount[AW-1:0];
                    cmd.wlen    = CW'(1);
                    n_cur_start = r_bcount[AW-1:0];
                    n_cur_len   = CW'(1);
                    n_wcount    = r_wcount + WCW'(1);
                    n_bcount    = r_bcount + CW'(1);
                    n_live      = 1'b1;
                end else begin
                    n_live    = 1'b0;
                    n_dropped = 1'b1;
                end
            end else if (r_live) begin
                // further byte of a stored word
                if (room_bytes) begin
                    push       = 1'b1;
                    cmd.widx   = wcount_m1[WIW-1:0];
                    cmd.wstart = r_cur_start;
                    cmd.wlen   = r_cur_len + CW'(1);
                    n_cur_len  = r_cur_len + CW'(1);
                    n_bcount   = r_bcount + CW'(1);
                end else begin
                    n_dropped = 1'b1;
                end
            end
        end
    end

    // string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcount  <= '0;
            r_wcount  <= '0;
            r_inside  <= 1'b0;
            r_live    <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_bcount  <= n_bcount;
            r_wcount  <= n_wcount;
            r_inside  <= n_inside;
            r_live    <= n_live;
            r_dropped <= n_dropped;
        end
    end

    // current word position, payload only
    always_ff @(posedge i_clk) begin
        r_cur_start <= n_cur_start;
        r_cur_len   <= n_cur_len;
    end

    assign o_push = push;
    assign o_cmd  = cmd;

endmodule

`default_nettype wire

[rtl/wor_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module wor_back #(
    parameter int BYTE_DEPTH = wor_pkg::BYTE_DEPTH,
    parameter int MAX_WORDS  = wor_pkg::MAX_WORDS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire wor_pkg::t_q_status i_q_status,
    input  wire [2 + $clog2(MAX_WORDS + 1) + 8 + 2 * $clog2(BYTE_DEPTH)
                 + (MAX_WORDS > 1 ? $clog2(MAX_WORDS) : 1)
                 + $clog2(BYTE_DEPTH + 1) - 1:0] i_cmd,
    output logic                o_pop,
    output logic                o_strobe,
    output logic [7:0]          o_out_byte,
    output logic                o_last,
    output logic                o_overflow
);

    localparam int AW  = $clog2(BYTE_DEPTH);
    localparam int CW  = $clog2(BYTE_DEPTH + 1);
    localparam int WIW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int WCW = $clog2(MAX_WORDS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WRD  = 3'd1;
    localparam logic [2:0] S_BYT  = 3'd2;
    localparam logic [2:0] S_SPC  = 3'd3;
    localparam logic [2:0] S_NL   = 3'd4;

    typedef struct packed {
        logic           is_end;
        logic           dropped;
        logic [WCW-1:0] wcount;
        logic [7:0]     data;
        logic [AW-1:0]  addr;
        logic [WIW-1:0] widx;
        logic [AW-1:0]  wstart;
        logic [CW-1:0]  wlen;
    } t_cmd;

    t_cmd           cmd;
    logic [2:0]     r_state;
    logic [2:0]     n_state;
    logic [WIW-1:0] r_widx;
    logic [WIW-1:0] n_widx;
    logic [AW-1:0]  r_ptr;
    logic [AW-1:0]  n_ptr;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;
    logic           r_ovf;
    logic           n_ovf;

    logic           r_strobe;
    logic [7:0]     r_byte;
    logic           r_last;
    logic           r_ovf_out;
    logic           n_strobe;
    logic [7:0]     n_byte;
    logic           n_last;
    logic           n_ovf_out;

    logic           pop;
    logic           store_we;
    logic [AW-1:0]  byte_raddr;
    logic [7:0]     byte_rdata;
    logic [WIW-1:0] word_raddr;
    logic [AW+CW-1:0] word_rdata;
    logic [AW-1:0]  rd_start;
    logic [CW-1:0]  rd_len;
    logic [WCW-1:0] wcount_m1;

    assign cmd       = i_cmd;
    assign pop       = (r_state == S_IDLE) && !i_q_status.empty;
    assign store_we  = pop && !cmd.is_end;
    assign rd_start  = word_rdata[AW+CW-1:CW];
    assign rd_len    = word_rdata[CW-1:0];
    assign wcount_m1 = cmd.wcount - WCW'(1);

    // word bytes
    wor_ram #(
        .WIDTH (8),
        .DEPTH (BYTE_DEPTH)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (cmd.addr),
        .i_wdata (cmd.data),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rdata)
    );

    // start and length of each word
    wor_ram #(
        .WIDTH (AW + CW),
        .DEPTH (MAX_WORDS)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (cmd.widx),
        .i_wdata ({cmd.wstart, cmd.wlen}),
        .i_raddr (word_raddr),
        .o_rdata (word_rdata)
    );

    // drain sequencer: words last to first, bytes in order, spaces between, closing newline
    always_comb begin
        n_state    = r_state;
        n_widx     = r_widx;
        n_ptr      = r_ptr;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        n_strobe   = 1'b0;
        n_byte     = r_byte;
        n_last     = 1'b0;
        n_ovf_out  = 1'b0;
        byte_raddr = r_ptr;
        word_raddr = r_widx;
        case (r_state)
            S_IDLE: begin
                if (pop && cmd.is_end) begin
                    n_ovf = cmd.dropped;
                    if (cmd.wcount == '0) begin
                        n_state = S_NL;
                    end else begin
                        word_raddr = wcount_m1[WIW-1:0];
                        n_widx     = wcount_m1[WIW-1:0];
                        n_state    = S_WRD;
                    end
                end
            end
            S_WRD: begin
                byte_raddr = rd_start;
                n_ptr      = rd_start;
                n_cnt      = rd_len;
                n_state    = S_BYT;
            end
            S_BYT: begin
                n_strobe = 1'b1;
                n_byte   = byte_rdata;
                if (r_cnt > CW'(1)) begin
                    byte_raddr = r_ptr + AW'(1);
                    n_ptr      = r_ptr + AW'(1);
                    n_cnt      = r_cnt - CW'(1);
                end else if (r_widx != '0) begin
                    word_raddr = r_widx - WIW'(1);
                    n_widx     = r_widx - WIW'(1);
                    n_state    = S_SPC;
                end else begin
                    n_state = S_NL;
                end
            end
            S_SPC: begin
                n_strobe   = 1'b1;
                n_byte     = wor_pkg::SPACE_BYTE;
                byte_raddr = rd_start;
                n_ptr      = rd_start;
                n_cnt      = rd_len;
                n_state    = S_BYT;
            end
            S_NL: begin
                n_strobe  = 1'b1;
                n_byte    = wor_pkg::NEWLINE_BYTE;
                n_last    = 1'b1;
                n_ovf_out = r_ovf;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_strobe  <= 1'b0;
            r_last    <= 1'b0;
            r_ovf_out <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_strobe  <= n_strobe;
            r_last    <= n_last;
            r_ovf_out <= n_ovf_out;
        end
    end

    // drain position and output byte
    always_ff @(posedge i_clk) begin
        r_widx <= n_widx;
        r_ptr  <= n_ptr;
        r_cnt  <= n_cnt;
        r_ovf  <= n_ovf;
        r_byte <= n_byte;
    end

    assign o_pop      = pop;
    assign o_strobe   = r_strobe;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;
    assign o_overflow = r_ovf_out;

endmodule

`default_nettype wire

[rtl/word_order_reverser.sv]
// String bytes: one item per cycle; busy rises only while the 4-entry command queue is full.
// End item: the newline closes the drain; once the end item reaches the drain sequencer, the
// word store and then the byte store are read (an empty string goes straight to its newline),
// then one byte per cycle. The receiver cannot stall: each result is shown for exactly one cycle under o_strobe.
// Reset (synchronous, active low) empties the queue, clears the string state and sets the
// separator to space; the byte and word stores are not cleared and are only read once written.
`timescale 1ns / 1ps
`default_nettype none

module word_order_reverser #(
    parameter int BYTE_DEPTH = wor_pkg::BYTE_DEPTH,
    parameter int MAX_WORDS  = wor_pkg::MAX_WORDS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [7:0]  i_cfg_data,
    input  wire        start,
    output logic       busy,
    input  wire [7:0]  i_ch,
    input  wire        i_is_end,
    output logic       o_strobe,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_overflow
);

    localparam int AW    = $clog2(BYTE_DEPTH);
    localparam int CW    = $clog2(BYTE_DEPTH + 1);
    localparam int WIW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int WCW   = $clog2(MAX_WORDS + 1);
    localparam int CMD_W = 2 + WCW + 8 + 2 * AW + WIW + CW;

    logic                q_push;
    logic                q_pop;
    logic [CMD_W-1:0]    front_cmd;
    logic [CMD_W-1:0]    back_cmd;
    wor_pkg::t_q_status  q_status;
    logic                accept;

    assign o_cfg_ready = 1'b1;
    assign busy        = q_status.full;
    assign accept      = start && !busy;

    // classify incoming bytes
    wor_front #(
        .BYTE_DEPTH (BYTE_DEPTH),
        .MAX_WORDS  (MAX_WORDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_ch        (i_ch),
        .i_is_end    (i_is_end),
        .o_push      (q_push),
        .o_cmd       (front_cmd)
    );

    // command queue
    wor_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (front_cmd),
        .i_pop    (q_pop),
        .o_data   (back_cmd),
        .o_status (q_status)
    );

    // store and drain
    wor_back #(
        .BYTE_DEPTH (BYTE_DEPTH),
        .MAX_WORDS  (MAX_WORDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_cmd      (back_cmd),
        .o_pop      (q_pop),
        .o_strobe   (o_strobe),
        .o_out_byte (o_out_byte),
        .o_last     (o_last),
        .o_overflow (o_overflow)
    );

    // overflow is only reported on the closing newline
    a_ovf_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_overflow |-> o_last)
        else $error("overflow flag outside the closing newline");

    // closing result is a strobed newline
    a_last_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_strobe && o_out_byte == wor_pkg::NEWLINE_BYTE))
        else $error("last result is not a strobed newline");

    // a string's closing newline is followed by a quiet gap before any further result
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result right after the closing newline");

    // the queue is never pushed while full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !q_push)
        else $error("command pushed into a full queue");

endmodule

`default_nettype wire
